// File: design/mqma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqma_pkg
// Shared types and codes for the multi-queue merge arbiter.
// ----------------------------------------------------------------------------
package mqma_pkg;

	// request function codes
	localparam logic [2:0] FUNC_FEED   = 3'd0;
	localparam logic [2:0] FUNC_MERGE  = 3'd1;
	localparam logic [2:0] FUNC_REMOVE = 3'd2;
	localparam logic [2:0] FUNC_CLEAR  = 3'd3;
	localparam logic [2:0] FUNC_STATS  = 3'd4;
	localparam logic [2:0] FUNC_TICK   = 3'd5;

	// merge policy codes
	localparam logic [1:0] POL_RR    = 2'd0;
	localparam logic [1:0] POL_PRIO  = 2'd1;
	localparam logic [1:0] POL_TIME  = 2'd2;
	localparam logic [1:0] POL_FIRST = 2'd3;

	// configuration register indexes
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_PRIO   = 1'b1;

	localparam logic [2:0] MAX_BYTES = 3'd4;

	// one queued entry (59 bits)
	typedef struct packed {
		logic [23:0] ts;
		logic [2:0]  nbytes;
		logic [31:0] data;
	} entry_t;

endpackage
`default_nettype wire

// File: design/multi_queue_merge_arbiter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_merge_arbiter_top
// Per-slot FIFO queues merged into one stream by a selectable policy.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Feed, remove, clear, stats reset and
// tick pass through an accept, an execute and a result-load step. A merge
// request walks the slots one at a time through one shared compare step (head
// read from the queue memory, then compare) per slot, followed by a head read
// and pop when a slot was picked; the scan ends early when round robin or
// first non-empty finds its slot. The input stalls while a request is in
// work; a finished result waits in the output register while the next
// request is taken, and a result that is still stalled there holds the
// sequencer in its result-load step.
module multi_queue_merge_arbiter_top #(
	parameter int NUM_SOURCES = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  func,
	input  wire logic [2:0]  source,
	input  wire logic [31:0] payload,
	input  wire logic [2:0]  byte_count,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             out_valid,
	output logic [2:0]       out_source,
	output logic [31:0]      out_payload,
	output logic [2:0]       out_bytes,
	output logic [23:0]      out_timestamp,
	output logic             queue_overflow,
	output logic [7:0]       pending_total,
	output logic             has_data,
	output logic [31:0]      merge_cycles,
	output logic [31:0]      entries_merged,
	output logic [47:0]      bytes_merged,
	output logic [31:0]      starvation_events,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int SW   = $clog2(NUM_SOURCES);
	localparam int HW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int AW   = $clog2(NUM_SOURCES * QUEUE_DEPTH);
	localparam int PW   = $clog2(NUM_SOURCES * QUEUE_DEPTH + 1);
	localparam int DEPTH = NUM_SOURCES * QUEUE_DEPTH;
	localparam int SUMW = HW + 2;

	localparam logic [SW-1:0]   LAST_SLOT = SW'(NUM_SOURCES - 1);
	localparam logic [SW:0]     NS_W      = (SW + 1)'(NUM_SOURCES);
	localparam logic [HW-1:0]   LAST_HEAD = HW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0]   QD_C      = CW'(QUEUE_DEPTH);
	localparam logic [SUMW-1:0] QD_S      = SUMW'(QUEUE_DEPTH);
	localparam logic [AW-1:0]   QD_A      = AW'(QUEUE_DEPTH);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SCAN_A = 3'd2;
	localparam logic [2:0] ST_SCAN_B = 3'd3;
	localparam logic [2:0] ST_POP_A  = 3'd4;
	localparam logic [2:0] ST_POP_B  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q;

	// configuration
	logic [1:0]  policy_q;
	logic [31:0] prio_q;

	// queue control
	logic [HW-1:0] heads_q [NUM_SOURCES];
	logic [CW-1:0] counts_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] reg_mask_q;
	logic [SW-1:0] rr_q;
	logic [23:0]   time_q;
	logic [PW-1:0] pend_q;

	// statistics
	logic [31:0] mcyc_q;
	logic [31:0] ment_q;
	logic [47:0] mbytes_q;
	logic [31:0] starv_q;

	// request capture
	logic [2:0]  func_q;
	logic [2:0]  src_q;
	logic [31:0] pay_q;
	logic [2:0]  nb_q;

	// scan
	logic [SW-1:0] idx_q;
	logic [SW-1:0] cur_q;
	logic [SW-1:0] pick_q;
	logic          found_q;
	logic [23:0]   best_ts_q;
	logic [3:0]    best_pr_q;

	// result scratch
	logic          r_valid_q;
	logic [2:0]    r_src_q;
	logic [31:0]   r_pay_q;
	logic [2:0]    r_bytes_q;
	logic [23:0]   r_ts_q;
	logic          r_ovf_q;

	// output register
	logic          res_valid_q;
	logic          o_valid_q;
	logic [2:0]    o_src_q;
	logic [31:0]   o_pay_q;
	logic [2:0]    o_bytes_q;
	logic [23:0]   o_ts_q;
	logic          o_ovf_q;
	logic [PW-1:0] o_pend_q;
	logic [31:0]   o_mcyc_q;
	logic [31:0]   o_ment_q;
	logic [47:0]   o_mbytes_q;
	logic [31:0]   o_starv_q;

	// queue memory
	mqma_pkg::entry_t mem [DEPTH];
	mqma_pkg::entry_t mem_rd_q;

	logic             accept;
	logic             cfg_wr;
	logic             src_ok;
	logic [SW-1:0]    src_slot;
	logic [SUMW-1:0]  tail_sum;
	logic [HW-1:0]    tail_ptr;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	mqma_pkg::entry_t mem_wd;
	logic [AW-1:0]    mem_ra;
	logic [SW-1:0]    scan_slot;
	logic [SW:0]      rr_sum;
	logic [SW-1:0]    cur_next;
	logic [7:0][3:0]  prio_v;
	logic [3:0]       cur_prio;
	logic             cur_nonempty;
	logic             take;
	logic             res_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign res_free = !res_valid_q || !res_stall;

	// configuration read
	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			mqma_pkg::REG_POLICY: prdata = {30'd0, policy_q};
			mqma_pkg::REG_PRIO:   prdata = prio_q;
			default:              prdata = 32'd0;
		endcase
	end

	// feed address: slot base plus wrapped tail
	assign src_ok   = (int'(src_q) < NUM_SOURCES);
	assign src_slot = SW'(src_q);
	assign tail_sum = SUMW'(heads_q[src_slot]) + SUMW'(counts_q[src_slot]);
	assign tail_ptr = (tail_sum >= QD_S) ? HW'(tail_sum - QD_S) : HW'(tail_sum);
	assign mem_we   = (state_q == ST_EXEC) && (func_q == mqma_pkg::FUNC_FEED) && src_ok &&
		(counts_q[src_slot] < QD_C);
	assign mem_wa   = AW'(src_slot) * QD_A + AW'(tail_ptr);
	assign mem_wd   = '{ts: time_q,
		nbytes: (nb_q > mqma_pkg::MAX_BYTES) ? mqma_pkg::MAX_BYTES : nb_q,
		data: pay_q};

	// slot visited in this scan step
	assign rr_sum    = (SW + 1)'(rr_q) + (SW + 1)'(idx_q);
	assign scan_slot = (policy_q != mqma_pkg::POL_RR) ? idx_q :
		((rr_sum >= NS_W) ? SW'(rr_sum - NS_W) : SW'(rr_sum));
	assign mem_ra    = (state_q == ST_SCAN_A) ?
		(AW'(scan_slot) * QD_A + AW'(heads_q[scan_slot])) :
		(AW'(pick_q) * QD_A + AW'(heads_q[pick_q]));

	// queue memory port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[mem_ra];
	end

	// compare step on the visited slot
	assign prio_v       = prio_q;
	assign cur_prio     = (int'(cur_q) < 8) ? prio_v[3'(cur_q)] : 4'd0;
	assign cur_nonempty = (counts_q[cur_q] != '0);
	assign cur_next     = (cur_q == LAST_SLOT) ? '0 : cur_q + 1'b1;
	always_comb begin
		case (policy_q)
			mqma_pkg::POL_PRIO: take = cur_nonempty && (!found_q || cur_prio > best_pr_q);
			mqma_pkg::POL_TIME: take = cur_nonempty && (!found_q || mem_rd_q.ts < best_ts_q);
			default:            take = cur_nonempty;
		endcase
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= mqma_pkg::POL_RR;
			prio_q      <= '0;
			reg_mask_q  <= '0;
			rr_q        <= '0;
			time_q      <= '0;
			pend_q      <= '0;
			mcyc_q      <= '0;
			ment_q      <= '0;
			mbytes_q    <= '0;
			starv_q     <= '0;
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			for (int i = 0; i < NUM_SOURCES; i++) begin
				heads_q[i]  <= '0;
				counts_q[i] <= '0;
			end
		end else begin
			// register writes
			if (cfg_wr) begin
				case (paddr[2])
					mqma_pkg::REG_POLICY: policy_q <= pwdata[1:0];
					mqma_pkg::REG_PRIO:   prio_q   <= pwdata;
					default:              ;
				endcase
			end

			// drop result once taken
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (func_q)
						mqma_pkg::FUNC_FEED: begin
							if (src_ok) begin
								reg_mask_q[src_slot] <= 1'b1;
								if (mem_we) begin
									counts_q[src_slot] <= counts_q[src_slot] + 1'b1;
									pend_q <= pend_q + 1'b1;
								end
							end
						end
						mqma_pkg::FUNC_MERGE: begin
							mcyc_q  <= mcyc_q + 1'b1;
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN_A;
						end
						mqma_pkg::FUNC_REMOVE: begin
							if (src_ok && reg_mask_q[src_slot]) begin
								reg_mask_q[src_slot] <= 1'b0;
								counts_q[src_slot]   <= '0;
								heads_q[src_slot]    <= '0;
								pend_q <= pend_q - PW'(counts_q[src_slot]);
							end
						end
						mqma_pkg::FUNC_CLEAR: begin
							for (int i = 0; i < NUM_SOURCES; i++) begin
								heads_q[i]  <= '0;
								counts_q[i] <= '0;
							end
							pend_q <= '0;
						end
						mqma_pkg::FUNC_STATS: begin
							mcyc_q   <= '0;
							ment_q   <= '0;
							mbytes_q <= '0;
							starv_q  <= '0;
						end
						mqma_pkg::FUNC_TICK: begin
							time_q <= time_q + 1'b1;
						end
						default: ;
					endcase
				end
				ST_SCAN_A: begin
					state_q <= ST_SCAN_B;
				end
				ST_SCAN_B: begin
					// advance to next slot unless this step ends the scan
					if (idx_q == LAST_SLOT) begin
						state_q <= (found_q || take) ? ST_POP_A : ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN_A;
					end
					if (policy_q == mqma_pkg::POL_RR) begin
						if (reg_mask_q[cur_q]) begin
							rr_q <= cur_next;
							if (cur_nonempty) begin
								found_q <= 1'b1;
								state_q <= ST_POP_A;
							end else begin
								starv_q <= starv_q + 1'b1;
							end
						end
					end else if (take) begin
						found_q <= 1'b1;
						if (policy_q == mqma_pkg::POL_FIRST) begin
							state_q <= ST_POP_A;
						end
					end
				end
				ST_POP_A: begin
					state_q <= ST_POP_B;
				end
				ST_POP_B: begin
					// pop the head of the picked slot
					heads_q[pick_q]  <= (heads_q[pick_q] == LAST_HEAD) ? '0 :
						heads_q[pick_q] + 1'b1;
					counts_q[pick_q] <= counts_q[pick_q] - 1'b1;
					pend_q           <= pend_q - 1'b1;
					if (mem_rd_q.nbytes != 3'd0) begin
						ment_q   <= ment_q + 1'b1;
						mbytes_q <= mbytes_q + 48'(mem_rd_q.nbytes);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture, scan bookkeeping and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			src_q     <= source;
			pay_q     <= payload;
			nb_q      <= byte_count;
			r_valid_q <= 1'b0;
			r_src_q   <= '0;
			r_pay_q   <= '0;
			r_bytes_q <= '0;
			r_ts_q    <= '0;
			r_ovf_q   <= 1'b0;
		end
		if (state_q == ST_EXEC && func_q == mqma_pkg::FUNC_FEED && src_ok && !mem_we) begin
			r_ovf_q <= 1'b1;
		end
		if (state_q == ST_SCAN_A) begin
			cur_q <= scan_slot;
		end
		if (state_q == ST_SCAN_B) begin
			if (policy_q == mqma_pkg::POL_RR) begin
				if (reg_mask_q[cur_q] && cur_nonempty) begin
					pick_q <= cur_q;
				end
			end else if (take) begin
				pick_q    <= cur_q;
				best_pr_q <= cur_prio;
				best_ts_q <= mem_rd_q.ts;
			end
		end
		if (state_q == ST_POP_B && mem_rd_q.nbytes != 3'd0) begin
			r_valid_q <= 1'b1;
			r_src_q   <= 3'(pick_q);
			r_pay_q   <= mem_rd_q.data;
			r_bytes_q <= mem_rd_q.nbytes;
			r_ts_q    <= mem_rd_q.ts;
		end
		// load output register
		if (state_q == ST_DONE && res_free) begin
			o_valid_q  <= r_valid_q;
			o_src_q    <= r_src_q;
			o_pay_q    <= r_pay_q;
			o_bytes_q  <= r_bytes_q;
			o_ts_q     <= r_ts_q;
			o_ovf_q    <= r_ovf_q;
			o_pend_q   <= pend_q;
			o_mcyc_q   <= mcyc_q;
			o_ment_q   <= ment_q;
			o_mbytes_q <= mbytes_q;
			o_starv_q  <= starv_q;
		end
	end

	assign res_valid         = res_valid_q;
	assign out_valid         = o_valid_q;
	assign out_source        = o_src_q;
	assign out_payload       = o_pay_q;
	assign out_bytes         = o_bytes_q;
	assign out_timestamp     = o_ts_q;
	assign queue_overflow    = o_ovf_q;
	assign pending_total     = 8'(o_pend_q);
	assign has_data          = (o_pend_q != '0);
	assign merge_cycles      = o_mcyc_q;
	assign entries_merged    = o_ment_q;
	assign bytes_merged      = o_mbytes_q;
	assign starvation_events = o_starv_q;

endmodule
`default_nettype wire

// File: sim/mqma_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqma_checker
// Tracks the merge arbiter's queues, policy and counters from the request
// and result channels, and compares every result with the expected one.
// ----------------------------------------------------------------------------
module mqma_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  func,
	input  wire logic [2:0]  source,
	input  wire logic [31:0] payload,
	input  wire logic [2:0]  byte_count,
	input  wire logic        res_valid,
	input  wire logic        res_stall,
	input  wire logic        out_valid,
	input  wire logic [2:0]  out_source,
	input  wire logic [31:0] out_payload,
	input  wire logic [2:0]  out_bytes,
	input  wire logic [23:0] out_timestamp,
	input  wire logic        queue_overflow,
	input  wire logic [7:0]  pending_total,
	input  wire logic        has_data,
	input  wire logic [31:0] merge_cycles,
	input  wire logic [31:0] entries_merged,
	input  wire logic [47:0] bytes_merged,
	input  wire logic [31:0] starvation_events,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               fail_count,
	output int               pending_results
);

	typedef struct packed {
		logic        valid;
		logic [2:0]  src;
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic [23:0] ts;
		logic        ovf;
		logic [7:0]  pending;
		logic        has;
		logic [31:0] merges;
		logic [31:0] entries;
		logic [47:0] bytes;
		logic [31:0] starves;
	} merge_result_t;

	mqma_pkg::entry_t slot_fifo [8][$];
	logic [7:0]    reg_mask;
	logic [2:0]    rr_ptr;
	logic [23:0]   tick_count;
	logic [31:0]   merge_cnt, entry_cnt, starve_cnt;
	logic [47:0]   byte_cnt;
	logic [1:0]    cur_policy;
	logic [31:0]   cur_prio;
	merge_result_t expected_results[$];

	assign pending_results = expected_results.size();

	// choose the slot to pop, or -1; round robin updates pointer and starvation
	function automatic int pick_slot();
		int best;
		logic [23:0] bestv;
		logic [3:0] bestp;
		logic [2:0] s;
		best = -1;
		bestv = '0;
		bestp = '0;
		if (cur_policy == mqma_pkg::POL_RR) begin
			for (int i = 0; i < 8; i++) begin
				s = rr_ptr + 3'(i);
				if (reg_mask[s]) begin
					rr_ptr = s + 3'd1;
					if (slot_fifo[s].size() != 0) return int'(s);
					starve_cnt++;
				end
			end
			return -1;
		end
		for (int k = 0; k < 8; k++) begin
			if (slot_fifo[k].size() == 0) continue;
			if (cur_policy == mqma_pkg::POL_FIRST) return k;
			if (cur_policy == mqma_pkg::POL_PRIO) begin
				if (best < 0 || cur_prio[4*k +: 4] > bestp) begin
					best = k;
					bestp = cur_prio[4*k +: 4];
				end
			end else if (best < 0 || slot_fifo[k][0].ts < bestv) begin
				best = k;
				bestv = slot_fifo[k][0].ts;
			end
		end
		return best;
	endfunction

	// apply one request and build its result
	function automatic merge_result_t apply_request(logic [2:0] f, logic [2:0] s,
			logic [31:0] d, logic [2:0] nb);
		merge_result_t r;
		mqma_pkg::entry_t e;
		int pick, total;
		r = '0;
		case (f)
			mqma_pkg::FUNC_FEED: begin
				reg_mask[s] = 1'b1;
				if (slot_fifo[s].size() >= 16) r.ovf = 1'b1;
				else begin
					e.data = d;
					e.nbytes = (nb > mqma_pkg::MAX_BYTES) ? mqma_pkg::MAX_BYTES : nb;
					e.ts = tick_count;
					slot_fifo[s].push_back(e);
				end
			end
			mqma_pkg::FUNC_MERGE: begin
				merge_cnt++;
				pick = pick_slot();
				if (pick >= 0) begin
					e = slot_fifo[pick].pop_front();
					if (e.nbytes != 0) begin
						r.valid = 1'b1;
						r.src = 3'(pick);
						r.data = e.data;
						r.nbytes = e.nbytes;
						r.ts = e.ts;
						entry_cnt++;
						byte_cnt += 48'(e.nbytes);
					end
				end
			end
			mqma_pkg::FUNC_REMOVE: begin
				if (reg_mask[s]) begin
					reg_mask[s] = 1'b0;
					slot_fifo[s].delete();
				end
			end
			mqma_pkg::FUNC_CLEAR: for (int k = 0; k < 8; k++) slot_fifo[k].delete();
			mqma_pkg::FUNC_STATS: begin
				merge_cnt = '0;
				entry_cnt = '0;
				byte_cnt = '0;
				starve_cnt = '0;
			end
			mqma_pkg::FUNC_TICK: tick_count++;
			default: ;
		endcase
		total = 0;
		for (int k = 0; k < 8; k++) total += slot_fifo[k].size();
		r.pending = 8'(total);
		r.has = (total != 0);
		r.merges = merge_cnt;
		r.entries = entry_cnt;
		r.bytes = byte_cnt;
		r.starves = starve_cnt;
		return r;
	endfunction

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		merge_result_t x;
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) slot_fifo[k].delete();
			reg_mask = '0;
			rr_ptr = '0;
			tick_count = '0;
			merge_cnt = '0;
			entry_cnt = '0;
			byte_cnt = '0;
			starve_cnt = '0;
			cur_policy = mqma_pkg::POL_RR;
			cur_prio = '0;
			expected_results.delete();
		end else begin
			// check a result before the same edge's request can add one
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request waiting");
					fail_count++;
				end else begin
					x = expected_results.pop_front();
					compare_field("out_valid", 64'(x.valid), 64'(out_valid));
					compare_field("out_source", 64'(x.src), 64'(out_source));
					compare_field("out_payload", 64'(x.data), 64'(out_payload));
					compare_field("out_bytes", 64'(x.nbytes), 64'(out_bytes));
					compare_field("out_timestamp", 64'(x.ts), 64'(out_timestamp));
					compare_field("queue_overflow", 64'(x.ovf), 64'(queue_overflow));
					compare_field("pending_total", 64'(x.pending), 64'(pending_total));
					compare_field("has_data", 64'(x.has), 64'(has_data));
					compare_field("merge_cycles", 64'(x.merges), 64'(merge_cycles));
					compare_field("entries_merged", 64'(x.entries), 64'(entries_merged));
					compare_field("bytes_merged", 64'(x.bytes), 64'(bytes_merged));
					compare_field("starvation_events", 64'(x.starves),
						64'(starvation_events));
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_request(func, source, payload, byte_count));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == mqma_pkg::REG_POLICY) cur_policy = pwdata[1:0];
				else cur_prio = pwdata;
			end
		end
	end

endmodule
`default_nettype wire

// File: sim/multi_queue_merge_arbiter_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_merge_arbiter_top_test
// Drives directed and random requests and register writes into the merge
// arbiter under varying idle patterns; the checker judges every result.
// ----------------------------------------------------------------------------
module multi_queue_merge_arbiter_top_test;

	logic        clk, arst_n;
	logic        in_valid, in_stall;
	logic [2:0]  func, source, byte_count;
	logic [31:0] payload;
	logic        res_valid, res_stall;
	logic        out_valid, queue_overflow, has_data;
	logic [2:0]  out_source, out_bytes;
	logic [31:0] out_payload, merge_cycles, entries_merged, starvation_events;
	logic [23:0] out_timestamp;
	logic [7:0]  pending_total;
	logic [47:0] bytes_merged;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fail_count, pending_results;
	int          send_idle_pct, recv_idle_pct;
	bit          hold_off;

	multi_queue_merge_arbiter_top dut (.*);
	mqma_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver stall, random or a long hold-off
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				res_stall <= 1'b0;
				hold_off = 1'b0;
			end else
				res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// offer one request and hold it until taken; valid stays up for the next call
	task automatic send(logic [2:0] f, logic [2:0] s, logic [31:0] d, logic [2:0] nb);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		source <= s;
		payload <= d;
		byte_count <= nb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every request is answered, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// random request, mostly feeds and merges
	task automatic random_request();
		int r;
		logic [2:0] f;
		r = $urandom_range(99);
		if (r < 42) f = mqma_pkg::FUNC_FEED;
		else if (r < 80) f = mqma_pkg::FUNC_MERGE;
		else if (r < 90) f = mqma_pkg::FUNC_TICK;
		else if (r < 94) f = mqma_pkg::FUNC_REMOVE;
		else if (r < 96) f = mqma_pkg::FUNC_CLEAR;
		else if (r < 98) f = mqma_pkg::FUNC_STATS;
		else f = 3'($urandom_range(7, 6));
		send(f, 3'($urandom_range(7)), $urandom(), 3'($urandom_range(7)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = '0;
		source = '0;
		payload = '0;
		byte_count = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 12;
		recv_idle_pct = 57;
		hold_off = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, empty data, oversize, overflow, every function
		send(mqma_pkg::FUNC_MERGE, 3'd0, '0, '0);
		send(mqma_pkg::FUNC_FEED, 3'd0, 32'hFFFF_FFFF, 3'd7);
		send(mqma_pkg::FUNC_FEED, 3'd7, 32'h0, 3'd0);
		send(mqma_pkg::FUNC_TICK, 3'd0, '0, '0);
		send(mqma_pkg::FUNC_FEED, 3'd3, 32'hA5A5_5A5A, 3'd4);
		send(mqma_pkg::FUNC_MERGE, 3'd0, '0, '0);
		send(mqma_pkg::FUNC_MERGE, 3'd0, '0, '0);
		send(mqma_pkg::FUNC_MERGE, 3'd0, '0, '0);
		send(mqma_pkg::FUNC_MERGE, 3'd0, '0, '0);
		for (int i = 0; i < 17; i++) send(mqma_pkg::FUNC_FEED, 3'd5, $urandom(), 3'd1);
		send(mqma_pkg::FUNC_REMOVE, 3'd5, '0, '0);
		send(3'd6, 3'd0, '0, '0);
		send(3'd7, 3'd0, '0, '0);
		send(mqma_pkg::FUNC_STATS, 3'd0, '0, '0);
		send(mqma_pkg::FUNC_CLEAR, 3'd0, '0, '0);
		drain();

		// pressure: long receiver hold-off while requests keep coming
		hold_off = 1'b1;
		for (int i = 0; i < 60; i++) random_request();
		drain();

		// random phases over policies and priorities, extremes included
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 57;
				recv_idle_pct = 12;
			end else if (ph == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(3'd0, 32'(ph % 4));
			write_reg(3'd4, (ph == 1) ? 32'hFFFF_FFFF : (ph == 5) ? 32'h0 : $urandom());
			for (int i = 0; i < 140; i++) begin
				if (ph % 3 == 2 && i < 40) send(mqma_pkg::FUNC_FEED, 3'($urandom_range(7)),
					$urandom(), 3'($urandom_range(4)));
				else random_request();
			end
			drain();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
